// ----- rtl/triangle_unit_normal_unit_defines.svh -----
// Assertion macros shared by the triangle unit normal RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef TRIANGLE_UNIT_NORMAL_UNIT_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TUN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define TUN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/tun_pkg.sv -----
// Package for the triangle unit normal block: widths, payload types, constants.
// No dependencies.
`default_nettype none
package tun_pkg;

	localparam int COORD_WIDTH = 16;
	// edges are pre-shifted so the cross product stays within 63 bits
	localparam int PRESHIFT    = (COORD_WIDTH > 30) ? COORD_WIDTH - 30 : 0;
	localparam int DIFF_W      = COORD_WIDTH + 1 - PRESHIFT;
	localparam int PROD_W      = 2 * DIFF_W;
	localparam int CROSS_W     = PROD_W + 1;
	localparam int NORM_W      = 32;
	localparam int NORM_SHIFT  = 30;
	localparam int EXT_W       = (CROSS_W > NORM_W) ? CROSS_W : NORM_W;
	localparam int BLEN_W      = $clog2(CROSS_W + 1);
	localparam int MAG_W       = 30;
	localparam int SQR_W       = 2 * MAG_W;
	localparam int SUM_W       = SQR_W + 2;
	localparam int ROOT_W      = SUM_W / 2;
	localparam int REM_W       = ROOT_W + 2;
	localparam int FRAC_BITS   = 14;
	localparam int OUT_W       = 16;
	localparam int QUO_W       = 16;
	localparam int DNUM_W      = MAG_W + FRAC_BITS + 1;
	localparam int DREM_W      = ROOT_W + 1;
	localparam int UNIT        = 16384;
	localparam int MID_DEPTH   = 4;
	localparam int OUT_DEPTH   = 2;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] a_x;
		logic signed [COORD_WIDTH-1:0] a_y;
		logic signed [COORD_WIDTH-1:0] a_z;
		logic signed [COORD_WIDTH-1:0] b_x;
		logic signed [COORD_WIDTH-1:0] b_y;
		logic signed [COORD_WIDTH-1:0] b_z;
		logic signed [COORD_WIDTH-1:0] c_x;
		logic signed [COORD_WIDTH-1:0] c_y;
		logic signed [COORD_WIDTH-1:0] c_z;
	} tri_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] norm_x;
		logic signed [OUT_W-1:0] norm_y;
		logic signed [OUT_W-1:0] norm_z;
		logic                    degenerate;
	} nrm_t;

	// classified cross product handed from front to back
	typedef struct packed {
		logic                      deg;
		logic signed [CROSS_W-1:0] n_x;
		logic signed [CROSS_W-1:0] n_y;
		logic signed [CROSS_W-1:0] n_z;
	} cross_t;

	// normalized components carried down the back pipeline
	typedef struct packed {
		logic                        deg;
		logic [2:0]                  neg;
		logic [2:0][MAG_W-1:0]       mag;
	} side_t;

	// edge difference hi - lo, floor-shifted by PRESHIFT
	function automatic logic signed [DIFF_W-1:0] edge_diff(
		input logic signed [COORD_WIDTH-1:0] hi,
		input logic signed [COORD_WIDTH-1:0] lo);
		logic signed [COORD_WIDTH:0] d;
		d = (COORD_WIDTH+1)'(hi) - (COORD_WIDTH+1)'(lo);
		return DIFF_W'(d >>> PRESHIFT);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/tun_fifo.sv -----
// Small register queue with first-word fall-through read.
// No package dependencies.
`default_nettype none
module tun_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end
endmodule
`default_nettype wire

// ----- rtl/tun_front.sv -----
// Front end: takes triangles, forms edges and cross product, flags degenerate ones.
// Depends on tun_pkg.
`default_nettype none
module tun_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire tun_pkg::tri_t in_data,
	input  wire logic          stall,
	output logic               out_valid,
	output tun_pkg::cross_t    out_data
);
	localparam int DW = tun_pkg::DIFF_W;
	localparam int PW = tun_pkg::PROD_W;
	localparam int XW = tun_pkg::CROSS_W;

	logic                 v_s1, v_s2, v_s3, v_s4;
	tun_pkg::tri_t        tri_s1;
	logic signed [DW-1:0] q_s2 [3];
	logic signed [DW-1:0] p_s2 [3];
	logic signed [PW-1:0] pr_s3 [6];
	tun_pkg::cross_t      cr_s4;
	tun_pkg::cross_t      cr_nxt;

	// valid bits move when the queue ahead has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// edges Q = b - a, P = c - a
	always_ff @(posedge clk) begin
		if (!stall) begin
			tri_s1  <= in_data;
			q_s2[0] <= tun_pkg::edge_diff(tri_s1.b_x, tri_s1.a_x);
			q_s2[1] <= tun_pkg::edge_diff(tri_s1.b_y, tri_s1.a_y);
			q_s2[2] <= tun_pkg::edge_diff(tri_s1.b_z, tri_s1.a_z);
			p_s2[0] <= tun_pkg::edge_diff(tri_s1.c_x, tri_s1.a_x);
			p_s2[1] <= tun_pkg::edge_diff(tri_s1.c_y, tri_s1.a_y);
			p_s2[2] <= tun_pkg::edge_diff(tri_s1.c_z, tri_s1.a_z);
		end
	end

	// six partial products of P x Q
	always_ff @(posedge clk) begin
		if (!stall) begin
			pr_s3[0] <= PW'(p_s2[1]) * PW'(q_s2[2]);
			pr_s3[1] <= PW'(p_s2[2]) * PW'(q_s2[1]);
			pr_s3[2] <= PW'(p_s2[2]) * PW'(q_s2[0]);
			pr_s3[3] <= PW'(p_s2[0]) * PW'(q_s2[2]);
			pr_s3[4] <= PW'(p_s2[0]) * PW'(q_s2[1]);
			pr_s3[5] <= PW'(p_s2[1]) * PW'(q_s2[0]);
		end
	end

	// cross product and degenerate check
	always_comb begin
		cr_nxt.n_x = XW'(pr_s3[0]) - XW'(pr_s3[1]);
		cr_nxt.n_y = XW'(pr_s3[2]) - XW'(pr_s3[3]);
		cr_nxt.n_z = XW'(pr_s3[4]) - XW'(pr_s3[5]);
		cr_nxt.deg = (cr_nxt.n_x == '0) && (cr_nxt.n_y == '0) && (cr_nxt.n_z == '0);
	end

	always_ff @(posedge clk) begin
		if (!stall)
			cr_s4 <= cr_nxt;
	end

	assign out_valid = v_s4;
	assign out_data  = cr_s4;
endmodule
`default_nettype wire

// ----- rtl/tun_back.sv -----
// Back end: scales the cross product, takes its length by a pipelined square root
// and divides each component by it in pipelined long division. Depends on tun_pkg.
`default_nettype none
module tun_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire tun_pkg::cross_t in_data,
	input  wire logic            stall,
	output logic                 out_valid,
	output tun_pkg::nrm_t        out_data
);
	localparam int XW  = tun_pkg::CROSS_W;
	localparam int NW  = tun_pkg::NORM_W;
	localparam int EW  = tun_pkg::EXT_W;
	localparam int BW  = tun_pkg::BLEN_W;
	localparam int MW  = tun_pkg::MAG_W;
	localparam int QW  = tun_pkg::SQR_W;
	localparam int SW  = tun_pkg::SUM_W;
	localparam int RW  = tun_pkg::ROOT_W;
	localparam int RMW = tun_pkg::REM_W;
	localparam int DNW = tun_pkg::DNUM_W;
	localparam int DRW = tun_pkg::DREM_W;
	localparam int OW  = tun_pkg::QUO_W;

	logic en;
	assign en = !stall;

	// ---------------- scaling stages ----------------
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	tun_pkg::cross_t      cr_s1, cr_s2, cr_s3;
	logic [XW-1:0]        or_s2;
	logic [BW-1:0]        blen_s3;
	logic signed [NW-1:0] nv_s4 [3];
	logic                 deg_s4;
	tun_pkg::side_t       sd_s5, sd_s6, sd_s7;
	logic [QW-1:0]        sq_s6 [3];
	logic [SW-1:0]        rad_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	function automatic logic [XW-1:0] cmag(input logic signed [XW-1:0] x);
		return x[XW-1] ? XW'(-x) : XW'(x);
	endfunction

	// OR of magnitudes has the bit length of the largest one
	logic [XW-1:0] or_nxt;
	assign or_nxt = cmag(cr_s1.n_x) | cmag(cr_s1.n_y) | cmag(cr_s1.n_z);

	// bit length: leading one position plus one
	logic [BW-1:0] blen_nxt;
	always_comb begin
		blen_nxt = '0;
		for (int i = 0; i < XW; i++)
			if (or_s2[i])
				blen_nxt = BW'(i + 1);
	end

	// shift so the largest magnitude has bit length NORM_SHIFT
	logic signed [NW-1:0] nv_nxt [3];
	always_comb begin
		logic                 up;
		logic [BW-1:0]        lsh, rsh;
		logic signed [EW-1:0] xc [3];
		up  = blen_s3 < BW'(tun_pkg::NORM_SHIFT);
		lsh = BW'(tun_pkg::NORM_SHIFT) - blen_s3;
		rsh = blen_s3 - BW'(tun_pkg::NORM_SHIFT);
		xc[0] = EW'(cr_s3.n_x);
		xc[1] = EW'(cr_s3.n_y);
		xc[2] = EW'(cr_s3.n_z);
		for (int i = 0; i < 3; i++)
			nv_nxt[i] = NW'(up ? (xc[i] <<< lsh) : (xc[i] >>> rsh));
	end

	// one more shift if a rounded-down negative reached 2^30
	tun_pkg::side_t sd_nxt;
	always_comb begin
		logic                 big;
		logic signed [NW-1:0] pm, vv, mm;
		big = 1'b0;
		for (int i = 0; i < 3; i++) begin
			pm  = nv_s4[i][NW-1] ? -nv_s4[i] : nv_s4[i];
			big = big | pm[tun_pkg::NORM_SHIFT];
		end
		sd_nxt.deg = deg_s4;
		for (int i = 0; i < 3; i++) begin
			vv = big ? (nv_s4[i] >>> 1) : nv_s4[i];
			mm = vv[NW-1] ? -vv : vv;
			sd_nxt.neg[i] = vv[NW-1];
			sd_nxt.mag[i] = MW'(mm);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cr_s1   <= in_data;
			cr_s2   <= cr_s1;
			or_s2   <= or_nxt;
			cr_s3   <= cr_s2;
			blen_s3 <= blen_nxt;
			nv_s4   <= nv_nxt;
			deg_s4  <= cr_s3.deg;
			sd_s5   <= sd_nxt;
			sd_s6   <= sd_s5;
			for (int i = 0; i < 3; i++)
				sq_s6[i] <= QW'(sd_s5.mag[i]) * QW'(sd_s5.mag[i]);
			sd_s7   <= sd_s6;
			rad_s7  <= SW'(sq_s6[0]) + SW'(sq_s6[1]) + SW'(sq_s6[2]);
		end
	end

	// ---------------- square root, one root bit per stage ----------------
	logic                 sq_v    [RW+1];
	logic [RMW-1:0]       sq_rem  [RW+1];
	logic [RW-1:0]        sq_root [RW+1];
	logic [SW-1:0]        sq_rad  [RW+1];
	tun_pkg::side_t       sq_sd   [RW+1];

	assign sq_v[0]    = v_s7;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = rad_s7;
	assign sq_sd[0]   = sd_s7;

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [RMW-1:0] rem2, trial;
		logic           fits;
		assign rem2  = {sq_rem[k][RMW-3:0], sq_rad[k][SW-1 -: 2]};
		assign trial = {sq_root[k], 2'b01};
		assign fits  = rem2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v[k+1] <= 1'b0;
			else if (en)
				sq_v[k+1] <= sq_v[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem[k+1]  <= fits ? rem2 - trial : rem2;
				sq_root[k+1] <= {sq_root[k][RW-2:0], fits};
				sq_rad[k+1]  <= sq_rad[k] << 2;
				sq_sd[k+1]   <= sq_sd[k];
			end
		end
	end

	// ---------------- rounded division, one quotient bit per stage ----------------
	logic                   dv_v   [OW+1];
	logic [2:0][DRW-1:0]    dv_rem [OW+1];
	logic [2:0][OW-1:0]     dv_low [OW+1];
	logic [2:0][OW-1:0]     dv_quo [OW+1];
	logic [RW-1:0]          dv_len [OW+1];
	tun_pkg::side_t         dv_sd  [OW+1];

	// numerator |n| * 2^14 + L/2
	logic [2:0][DNW-1:0] num;
	always_comb begin
		for (int i = 0; i < 3; i++)
			num[i] = (DNW'(sq_sd[RW].mag[i]) << tun_pkg::FRAC_BITS)
				+ DNW'(sq_root[RW] >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v[0] <= 1'b0;
		else if (en)
			dv_v[0] <= sq_v[RW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dv_rem[0][i] <= DRW'(num[i] >> OW);
				dv_low[0][i] <= num[i][OW-1:0];
				dv_quo[0][i] <= '0;
			end
			dv_len[0] <= sq_root[RW];
			dv_sd[0]  <= sq_sd[RW];
		end
	end

	for (genvar j = 0; j < OW; j++) begin : g_div
		logic [2:0][DRW-1:0] r2;
		logic [2:0]          ge;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				r2[i] = {dv_rem[j][i][DRW-2:0], dv_low[j][i][OW-1]};
				ge[i] = r2[i] >= DRW'(dv_len[j]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v[j+1] <= 1'b0;
			else if (en)
				dv_v[j+1] <= dv_v[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem[j+1][i] <= ge[i] ? r2[i] - DRW'(dv_len[j]) : r2[i];
					dv_low[j+1][i] <= dv_low[j][i] << 1;
					dv_quo[j+1][i] <= {dv_quo[j][i][OW-2:0], ge[i]};
				end
				dv_len[j+1] <= dv_len[j];
				dv_sd[j+1]  <= dv_sd[j];
			end
		end
	end

	// ---------------- clamp, sign, degenerate ----------------
	logic            v_out;
	tun_pkg::nrm_t   res_out;
	logic [2:0][OW-1:0] comp;
	always_comb begin
		logic [OW-1:0] r;
		for (int i = 0; i < 3; i++) begin
			r = (dv_quo[OW][i] > OW'(tun_pkg::UNIT)) ? OW'(tun_pkg::UNIT) : dv_quo[OW][i];
			r = dv_sd[OW].neg[i] ? -r : r;
			comp[i] = dv_sd[OW].deg ? '0 : r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_out <= 1'b0;
		else if (en)
			v_out <= dv_v[OW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_out.norm_x     <= comp[0];
			res_out.norm_y     <= comp[1];
			res_out.norm_z     <= comp[2];
			res_out.degenerate <= dv_sd[OW].deg;
		end
	end

	assign out_valid = v_out;
	assign out_data  = res_out;
endmodule
`default_nettype wire

// ----- rtl/triangle_unit_normal_unit.sv -----
// Unit face normal of a triangle: front end, queue, back end, result queue.
// Stages: 4 in the front, 56 in the back (7 scaling, 31 square root, 17 division,
// 1 output), with a queue after each. Throughput: one triangle per cycle; the
// whole back pipeline holds while the result queue is full, the front while the
// middle one is.
// Reset: arst_n clears valid bits and queue pointers; data registers are not reset.
`default_nettype none
`include "triangle_unit_normal_unit_defines.svh"
module triangle_unit_normal_unit #(
	parameter int MID_DEPTH = tun_pkg::MID_DEPTH,
	parameter int OUT_DEPTH = tun_pkg::OUT_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire tun_pkg::tri_t vertices,
	output logic               full,
	input  wire logic          pop,
	output tun_pkg::nrm_t      normal,
	output logic               empty
);
	localparam int MID_W = $bits(tun_pkg::cross_t);
	localparam int OUT_W = $bits(tun_pkg::nrm_t);

	logic             fr_valid, mid_full, mid_empty, mid_pop;
	tun_pkg::cross_t  fr_data, bk_in;
	logic [MID_W-1:0] mid_rdata;
	logic             bk_valid, out_full;
	tun_pkg::nrm_t    bk_data;
	logic [OUT_W-1:0] out_rdata;

	// front takes a transfer whenever the middle queue has room
	assign full = mid_full;

	tun_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (push && !mid_full),
		.in_data  (vertices),
		.stall    (mid_full),
		.out_valid(fr_valid),
		.out_data (fr_data)
	);

	tun_fifo #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fr_valid && !mid_full),
		.wdata (fr_data),
		.full  (mid_full),
		.pop   (mid_pop),
		.rdata (mid_rdata),
		.empty (mid_empty)
	);

	assign mid_pop = !mid_empty && !out_full;
	assign bk_in   = tun_pkg::cross_t'(mid_rdata);

	tun_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mid_pop),
		.in_data  (bk_in),
		.stall    (out_full),
		.out_valid(bk_valid),
		.out_data (bk_data)
	);

	tun_fifo #(.WIDTH(OUT_W), .DEPTH(OUT_DEPTH)) u_out (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (bk_valid && !out_full),
		.wdata (bk_data),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_rdata),
		.empty (empty)
	);

	assign normal = tun_pkg::nrm_t'(out_rdata);

	// checks
	`TUN_ASSERT_IMP(a_deg_zero, (!empty && normal.degenerate),
		(normal.norm_x == '0 && normal.norm_y == '0 && normal.norm_z == '0),
		"degenerate result with nonzero components")
	`TUN_ASSERT_IMP(a_nonzero, (!empty && !normal.degenerate),
		(normal.norm_x != '0 || normal.norm_y != '0 || normal.norm_z != '0),
		"regular result with all components zero")
	`TUN_ASSERT_IMP(a_range, !empty,
		(normal.norm_x <= 16'sd16384 && normal.norm_x >= -16'sd16384 &&
		 normal.norm_y <= 16'sd16384 && normal.norm_y >= -16'sd16384 &&
		 normal.norm_z <= 16'sd16384 && normal.norm_z >= -16'sd16384),
		"normal component out of unit range")
	`TUN_ASSERT_NXT(a_mid_hold, (mid_full && !mid_pop), mid_full,
		"middle queue lost an entry while stalled")
endmodule
`default_nettype wire
